// ----- src/rhsl_pkg.sv -----
// shared types, constants and the restoring divide step for the rgbc to hsl converter
// no dependencies
package rhsl_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int DIV_STEPS = 7;
    localparam int REM_W = 23;
    localparam int DVS_W = 16;

    typedef struct packed {
        logic        inv;
        logic [2:0]  sat;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] clr;
    } front_item_t;

    typedef struct packed {
        logic                        inv;
        logic [2:0]                  sat;
        logic [2:0][REM_W-1:0]       rem;
        logic [DVS_W-1:0]            dvs;
        logic [2:0][DIV_STEPS-1:0]   q;
    } pct_stage_t;

    typedef struct packed {
        logic                  inv;
        logic                  grey;
        logic                  neg;
        logic [8:0]            off;
        logic [6:0]            lgt;
        logic [REM_W-1:0]      hrem;
        logic [DVS_W-1:0]      hdv;
        logic [DIV_STEPS-1:0]  hq;
        logic [REM_W-1:0]      srem;
        logic [DVS_W-1:0]      sdv;
        logic [DIV_STEPS-1:0]  sq;
    } hsl_stage_t;

    // one restoring step: quotient bit on top, new remainder below
    function automatic logic [REM_W:0] div_step(
        input logic [REM_W-1:0] rem,
        input logic [DVS_W-1:0] dvs,
        input int               idx
    );
        logic [REM_W-1:0] sh;
        sh = {{(REM_W-DVS_W){1'b0}}, dvs} << idx;
        if (rem >= sh)
            return {1'b1, rem - sh};
        return {1'b0, rem};
    endfunction

endpackage

// ----- src/rhsl_front.sv -----
// front stage: takes an item, flags zero clear and channels at or above clear
// depends on rhsl_pkg
module rhsl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  logic [15:0]          red_count,
    input  logic [15:0]          green_count,
    input  logic [15:0]          blue_count,
    input  logic [15:0]          clear_count,
    input  logic                 q_full,
    output logic                 push,
    output rhsl_pkg::front_item_t push_item
);
    import rhsl_pkg::*;

    front_item_t item_reg;
    logic        valid_reg;
    logic        accept;

    assign sample_stall = valid_reg && q_full;
    assign accept       = sample_valid && !sample_stall;
    assign push         = valid_reg && !q_full;
    assign push_item    = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.inv   <= (clear_count == 16'd0);
            item_reg.sat   <= {blue_count >= clear_count, green_count >= clear_count,
                               red_count >= clear_count};
            item_reg.red   <= red_count;
            item_reg.green <= green_count;
            item_reg.blue  <= blue_count;
            item_reg.clr   <= clear_count;
        end
    end

endmodule

// ----- src/rhsl_queue.sv -----
// small item queue between front and back
// depends on rhsl_pkg
module rhsl_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rhsl_pkg::front_item_t push_item,
    input  logic                  pop,
    output logic                  full,
    output logic                  nonempty,
    output rhsl_pkg::front_item_t head
);
    import rhsl_pkg::*;

    front_item_t           mem [QDEPTH];
    logic [QPTR_W-1:0]     wr_reg;
    logic [QPTR_W-1:0]     rd_reg;
    logic [QPTR_W:0]       cnt_reg;
    logic                  do_pop;

    assign full     = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign nonempty = (cnt_reg != '0);
    assign head     = mem[rd_reg];
    assign do_pop   = pop && nonempty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

endmodule

// ----- src/rhsl_back.sv -----
// back pipeline: percent dividers, max/min and sector setup, hue and saturation dividers
// depends on rhsl_pkg
module rhsl_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_nonempty,
    input  rhsl_pkg::front_item_t q_head,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [8:0]            hue_deg,
    output logic [6:0]            saturation_pct,
    output logic [6:0]            lightness_pct,
    output logic                  invalid
);
    import rhsl_pkg::*;

    pct_stage_t a_reg  [DIV_STEPS+1];
    pct_stage_t a_next [DIV_STEPS+1];
    hsl_stage_t b_reg  [DIV_STEPS+1];
    hsl_stage_t b_next [DIV_STEPS+1];
    logic [DIV_STEPS:0] av_reg;
    logic [DIV_STEPS:0] bv_reg;
    logic               en;

    logic [6:0]  pr, pg, pb, mx, mn, d, mag;
    logic [7:0]  sum;
    logic [REM_W:0] st;
    logic [8:0]  h;
    hsl_stage_t  fin;

    logic        valid_reg;
    logic [8:0]  hue_reg;
    logic [6:0]  sat_reg;
    logic [6:0]  lgt_reg;
    logic        inv_reg;

    assign en  = !(valid_reg && result_stall);
    assign pop = en && q_nonempty;

    always_comb
    begin
        a_next[0].inv = q_head.inv;
        a_next[0].sat = q_head.sat;
        a_next[0].dvs = q_head.clr;
        a_next[0].q   = '0;
        a_next[0].rem[0] = {7'b0, q_head.red} * 23'd100;
        a_next[0].rem[1] = {7'b0, q_head.green} * 23'd100;
        a_next[0].rem[2] = {7'b0, q_head.blue} * 23'd100;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            a_next[k] = a_reg[k-1];
            for (int c = 0; c < 3; c++)
            begin
                st = div_step(a_reg[k-1].rem[c], a_reg[k-1].dvs, DIV_STEPS - k);
                a_next[k].rem[c] = st[REM_W-1:0];
                a_next[k].q[c]   = {a_reg[k-1].q[c][DIV_STEPS-2:0], st[REM_W]};
            end
        end

        // percentages, saturated at 100
        pr = a_reg[DIV_STEPS].sat[0] ? 7'd100 : a_reg[DIV_STEPS].q[0];
        pg = a_reg[DIV_STEPS].sat[1] ? 7'd100 : a_reg[DIV_STEPS].q[1];
        pb = a_reg[DIV_STEPS].sat[2] ? 7'd100 : a_reg[DIV_STEPS].q[2];
        mx = pr;
        if (pg > mx) mx = pg;
        if (pb > mx) mx = pb;
        mn = pr;
        if (pg < mn) mn = pg;
        if (pb < mn) mn = pb;
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};

        b_next[0].inv  = a_reg[DIV_STEPS].inv;
        b_next[0].grey = (d == 7'd0);
        b_next[0].lgt  = sum[7:1];
        if (mx == pr)
        begin
            b_next[0].neg = (pg < pb);
            b_next[0].off = (pg < pb) ? 9'd360 : 9'd0;
            mag = (pg < pb) ? pb - pg : pg - pb;
        end
        else if (mx == pg)
        begin
            b_next[0].neg = (pb < pr);
            b_next[0].off = 9'd120;
            mag = (pb < pr) ? pr - pb : pb - pr;
        end
        else
        begin
            b_next[0].neg = (pr < pg);
            b_next[0].off = 9'd240;
            mag = (pr < pg) ? pg - pr : pr - pg;
        end
        b_next[0].hrem = {16'b0, mag} * 23'd60;
        b_next[0].hdv  = {9'b0, d};
        b_next[0].hq   = '0;
        b_next[0].srem = {16'b0, d} * 23'd100;
        b_next[0].sdv  = (sum[7:1] <= 7'd50) ? {8'b0, sum} : {8'b0, 8'd200 - sum};
        b_next[0].sq   = '0;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            b_next[k] = b_reg[k-1];
            st = div_step(b_reg[k-1].hrem, b_reg[k-1].hdv, DIV_STEPS - k);
            b_next[k].hrem = st[REM_W-1:0];
            b_next[k].hq   = {b_reg[k-1].hq[DIV_STEPS-2:0], st[REM_W]};
            st = div_step(b_reg[k-1].srem, b_reg[k-1].sdv, DIV_STEPS - k);
            b_next[k].srem = st[REM_W-1:0];
            b_next[k].sq   = {b_reg[k-1].sq[DIV_STEPS-2:0], st[REM_W]};
        end

        fin = b_reg[DIV_STEPS];
        h = fin.neg ? fin.off - {2'b0, fin.hq} : fin.off + {2'b0, fin.hq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            av_reg    <= '0;
            bv_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            av_reg    <= {av_reg[DIV_STEPS-1:0], q_nonempty};
            bv_reg    <= {bv_reg[DIV_STEPS-1:0], av_reg[DIV_STEPS]};
            valid_reg <= bv_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                a_reg[k] <= a_next[k];
                b_reg[k] <= b_next[k];
            end
            inv_reg <= fin.inv;
            lgt_reg <= fin.inv ? 7'd0 : fin.lgt;
            hue_reg <= (fin.inv || fin.grey) ? 9'd0 : h;
            sat_reg <= (fin.inv || fin.grey) ? 7'd0 : fin.sq;
        end
    end

    assign result_valid   = valid_reg;
    assign hue_deg        = hue_reg;
    assign saturation_pct = sat_reg;
    assign lightness_pct  = lgt_reg;
    assign invalid        = inv_reg;

endmodule

// ----- src/rgbc_to_hsl_converter_core.sv -----
// rgbc to hsl converter top level: front, item queue and back pipeline
// depends on rhsl_pkg, rhsl_front, rhsl_queue, rhsl_back
// One item may enter every clock cycle while the queue is not full. Between an accepted
// item and its result lie, in order: the front register that takes the item at the accepting edge,
// then one queue slot, one stage that forms the scaled products, seven restoring-divide
// stages for the three channel percentages, one max/min stage, seven shared-step stages
// that divide hue and saturation side by side, and the result register. A four-item queue
// between front and back absorbs short stalls on either side.
module rgbc_to_hsl_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic [15:0] red_count,
    input  logic [15:0] green_count,
    input  logic [15:0] blue_count,
    input  logic [15:0] clear_count,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [8:0]  hue_deg,
    output logic [6:0]  saturation_pct,
    output logic [6:0]  lightness_pct,
    output logic        invalid
);
    import rhsl_pkg::*;

    front_item_t push_item;
    front_item_t head;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_nonempty;

    rhsl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .red_count    (red_count),
        .green_count  (green_count),
        .blue_count   (blue_count),
        .clear_count  (clear_count),
        .q_full       (q_full),
        .push         (push),
        .push_item    (push_item)
    );

    rhsl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .head      (head)
    );

    rhsl_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_nonempty     (q_nonempty),
        .q_head         (head),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .hue_deg        (hue_deg),
        .saturation_pct (saturation_pct),
        .lightness_pct  (lightness_pct),
        .invalid        (invalid)
    );

endmodule
